### sv/bpc_pkg.sv
// Package for the button press classifier.
// Holds widths, event codes, register indexes, reset values and the limit struct.
// No dependencies.
package bpc_pkg;

    localparam int TIME_BITS    = 32;
    localparam int LAP_BITS     = 16;
    localparam int LIMIT_BITS   = 16;
    localparam int EVENT_BITS   = 2;
    localparam int CFG_IDX_BITS = 2;

    typedef logic [EVENT_BITS-1:0]   event_t;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
    typedef logic [LIMIT_BITS-1:0]   limit_t;
    typedef logic [TIME_BITS-1:0]    time_t;
    typedef logic [LAP_BITS-1:0]     lap_t;

    localparam event_t EV_NONE      = 2'd0;
    localparam event_t EV_DOUBLE    = 2'd1;
    localparam event_t EV_LONG      = 2'd2;
    localparam event_t EV_VERY_LONG = 2'd3;

    localparam cfg_idx_t REG_SHORT_LIMIT     = 2'd0;
    localparam cfg_idx_t REG_DOUBLE_WINDOW   = 2'd1;
    localparam cfg_idx_t REG_LONG_LIMIT      = 2'd2;
    localparam cfg_idx_t REG_VERY_LONG_LIMIT = 2'd3;

    localparam limit_t RST_SHORT_LIMIT     = 16'd150;
    localparam limit_t RST_DOUBLE_WINDOW   = 16'd500;
    localparam limit_t RST_LONG_LIMIT      = 16'd3000;
    localparam limit_t RST_VERY_LONG_LIMIT = 16'd6000;

    typedef struct packed {
        limit_t short_limit;
        limit_t double_window;
        limit_t long_limit;
        limit_t very_long_limit;
    } cfg_t;

endpackage

### sv/bpc_cfg_regs.sv
// Configuration registers of the button press classifier.
// Depends on bpc_pkg for the register indexes, reset values and cfg_t.
module bpc_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  bpc_pkg::cfg_idx_t cfg_index,
    input  bpc_pkg::limit_t   cfg_data,
    output bpc_pkg::cfg_t     cfg
);

    bpc_pkg::cfg_t cfg_reg;
    bpc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                bpc_pkg::REG_SHORT_LIMIT:     cfg_next.short_limit     = cfg_data;
                bpc_pkg::REG_DOUBLE_WINDOW:   cfg_next.double_window   = cfg_data;
                bpc_pkg::REG_LONG_LIMIT:      cfg_next.long_limit      = cfg_data;
                bpc_pkg::REG_VERY_LONG_LIMIT: cfg_next.very_long_limit = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_limit     <= bpc_pkg::RST_SHORT_LIMIT;
            cfg_reg.double_window   <= bpc_pkg::RST_DOUBLE_WINDOW;
            cfg_reg.long_limit      <= bpc_pkg::RST_LONG_LIMIT;
            cfg_reg.very_long_limit <= bpc_pkg::RST_VERY_LONG_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/bpc_classify.sv
// Press tracking state and classification logic of the button press classifier.
// Depends on bpc_pkg for widths, event codes and cfg_t.
module bpc_classify (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fire,
    input  logic            level,
    input  bpc_pkg::time_t  now,
    input  bpc_pkg::cfg_t   cfg,
    output bpc_pkg::event_t evt,
    output bpc_pkg::lap_t   lap
);

    logic           held_reg;
    logic           held_next;
    bpc_pkg::time_t start_reg;
    bpc_pkg::time_t start_next;
    logic           wait_reg;
    logic           wait_next;
    bpc_pkg::time_t release_reg;
    bpc_pkg::time_t release_next;
    bpc_pkg::lap_t  lap_reg;
    bpc_pkg::lap_t  lap_next;

    bpc_pkg::time_t dur;
    bpc_pkg::time_t gap;
    logic           is_short;
    logic           in_window;
    logic           at_long;
    logic           at_very_long;

    // Differences wrap modulo the timestamp width.
    assign dur          = now - start_reg;
    assign gap          = now - release_reg;
    assign is_short     = dur < bpc_pkg::TIME_BITS'(cfg.short_limit);
    assign in_window    = gap < bpc_pkg::TIME_BITS'(cfg.double_window);
    assign at_long      = dur >= bpc_pkg::TIME_BITS'(cfg.long_limit);
    assign at_very_long = dur >= bpc_pkg::TIME_BITS'(cfg.very_long_limit);

    always_comb begin
        held_next    = held_reg;
        start_next   = start_reg;
        wait_next    = wait_reg;
        release_next = release_reg;
        lap_next     = lap_reg;
        evt          = bpc_pkg::EV_NONE;
        if (level && !held_reg) begin
            held_next  = 1'b1;
            start_next = now;
        end else if (!level && held_reg) begin
            held_next = 1'b0;
            if (is_short) begin
                if (wait_reg && in_window) begin
                    evt       = bpc_pkg::EV_DOUBLE;
                    lap_next  = lap_reg + bpc_pkg::lap_t'(1);
                    wait_next = 1'b0;
                end else begin
                    // open a new window at this release
                    wait_next    = 1'b1;
                    release_next = now;
                end
            end else if (at_long && !at_very_long) begin
                evt = bpc_pkg::EV_LONG;
            end else if (at_very_long) begin
                evt = bpc_pkg::EV_VERY_LONG;
            end
        end
    end

    assign lap = lap_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= 1'b0;
            start_reg   <= '0;
            wait_reg    <= 1'b0;
            release_reg <= '0;
            lap_reg     <= '0;
        end else if (fire) begin
            held_reg    <= held_next;
            start_reg   <= start_next;
            wait_reg    <= wait_next;
            release_reg <= release_next;
            lap_reg     <= lap_next;
        end
    end

endmodule

### sv/button_press_classifier.sv
// Button press classifier: each input word is a button level sample with a millisecond
// timestamp, and each one yields exactly one result word with the press event (none,
// double, long, very long) and the lap counter after that sample. The block is a
// two-register pipeline: the sample is captured in an input register, classified by a
// few subtractions and compares against the four limit registers, and the result is
// registered in an output register. While the result side does not stall it takes one
// word per cycle; the press state updates in the same cycle a sample is classified. The
// user must write limits through the cfg port only while no words are in flight; the
// block does not enforce this. Writes take effect on the next sample.
// Depends on bpc_pkg, bpc_cfg_regs and bpc_classify.
module button_press_classifier (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_button_level,
    input  logic [31:0]             s_time_ms,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_press_event,
    output logic [15:0]             m_lap_number,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [15:0]             cfg_data
);

    bpc_pkg::cfg_t   cfg;
    logic            in_valid_reg;
    logic            in_level_reg;
    bpc_pkg::time_t  in_time_reg;
    logic            out_valid_reg;
    bpc_pkg::event_t out_event_reg;
    bpc_pkg::lap_t   out_lap_reg;
    bpc_pkg::event_t evt_next;
    bpc_pkg::lap_t   lap_next;
    logic            advance;
    logic            fire;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    bpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpc_classify u_classify (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .level   (in_level_reg),
        .now     (in_time_reg),
        .cfg     (cfg),
        .evt     (evt_next),
        .lap     (lap_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_level_reg <= s_button_level;
            in_time_reg  <= bpc_pkg::TIME_BITS'(s_time_ms);
        end
        if (fire) begin
            out_event_reg <= evt_next;
            out_lap_reg   <= lap_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_press_event = out_event_reg;
    assign m_lap_number  = out_lap_reg;

endmodule

### sv/bpc_checker.sv
// Port-level checks for the button press classifier, bound to the top level.
// Depends on bpc_pkg for the event codes.
module bpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_press_event,
    input logic [15:0] m_lap_number,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_press_event) && $stable(m_lap_number))
        else $error("result word changed while stalled");

    // With the output side empty the input side must take a word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // Lap counter holds across consecutive words that are not a double press.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) ##1 (m_valid && m_press_event != bpc_pkg::EV_DOUBLE)
        |-> m_lap_number == $past(m_lap_number))
        else $error("lap counter moved without a double press");

    // A double press bumps the lap counter by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) ##1 (m_valid && m_press_event == bpc_pkg::EV_DOUBLE)
        |-> m_lap_number == 16'($past(m_lap_number) + 16'd1))
        else $error("double press did not advance lap counter");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_press_event (m_press_event),
    .m_lap_number  (m_lap_number),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);

### dv/button_press_classifier_checker.sv
// Scoreboard for the button press classifier: watches the sample, result and limit
// write channels, predicts every result word and compares it field by field.
// Depends on bpc_pkg.
module button_press_classifier_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_button_level,
    input  logic [31:0] s_time_ms,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_press_event,
    input  logic [15:0] m_lap_number,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          waiting
);

    typedef struct packed {
        bpc_pkg::event_t press_event;
        bpc_pkg::lap_t   lap_number;
    } press_result_t;

    press_result_t expected_results[$];
    int            results_seen;

    bpc_pkg::cfg_t  limits;
    logic           held;
    bpc_pkg::time_t press_start;
    logic           wait_second;
    bpc_pkg::time_t short_release;
    bpc_pkg::lap_t  laps;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] word %0d: %s: got %0d, expected %0d",
                 $time, results_seen, what, got, want);
        errors++;
    endtask

    // Advance the press state by one sample and return the word it yields.
    function automatic press_result_t classify_sample(input logic level,
                                                      input bpc_pkg::time_t now);
        bpc_pkg::time_t dur;
        bpc_pkg::time_t gap;
        press_result_t  res;
        res.press_event = bpc_pkg::EV_NONE;
        if (level && !held) begin
            held        = 1'b1;
            press_start = now;
        end else if (!level && held) begin
            dur  = now - press_start;
            held = 1'b0;
            if (dur < bpc_pkg::TIME_BITS'(limits.short_limit)) begin
                gap = now - short_release;
                if (wait_second && gap < bpc_pkg::TIME_BITS'(limits.double_window)) begin
                    res.press_event = bpc_pkg::EV_DOUBLE;
                    laps            = laps + bpc_pkg::lap_t'(1);
                    wait_second     = 1'b0;
                end else begin
                    wait_second   = 1'b1;
                    short_release = now;
                end
            end else if (dur >= bpc_pkg::TIME_BITS'(limits.long_limit) &&
                         dur < bpc_pkg::TIME_BITS'(limits.very_long_limit)) begin
                res.press_event = bpc_pkg::EV_LONG;
            end else if (dur >= bpc_pkg::TIME_BITS'(limits.very_long_limit)) begin
                res.press_event = bpc_pkg::EV_VERY_LONG;
            end
        end
        res.lap_number = laps;
        return res;
    endfunction

    always @(posedge aclk) begin : monitor
        press_result_t want;
        if (!aresetn) begin
            limits.short_limit     = bpc_pkg::RST_SHORT_LIMIT;
            limits.double_window   = bpc_pkg::RST_DOUBLE_WINDOW;
            limits.long_limit      = bpc_pkg::RST_LONG_LIMIT;
            limits.very_long_limit = bpc_pkg::RST_VERY_LONG_LIMIT;
            held          = 1'b0;
            press_start   = '0;
            wait_second   = 1'b0;
            short_release = '0;
            laps          = '0;
            expected_results.delete();
            results_seen  = 0;
            errors        = 0;
            waiting       = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    bpc_pkg::REG_SHORT_LIMIT:     limits.short_limit     = cfg_data;
                    bpc_pkg::REG_DOUBLE_WINDOW:   limits.double_window   = cfg_data;
                    bpc_pkg::REG_LONG_LIMIT:      limits.long_limit      = cfg_data;
                    bpc_pkg::REG_VERY_LONG_LIMIT: limits.very_long_limit = cfg_data;
                    default: ;
                endcase
            end
            // Check the outgoing word before queuing the incoming one: a sample is
            // registered before its word leaves, so the two never share an edge.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with nothing pending, press_event",
                                    m_press_event, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_press_event !== want.press_event)
                        report_mismatch("press_event", m_press_event, want.press_event);
                    if (m_lap_number !== want.lap_number)
                        report_mismatch("lap_number", m_lap_number, want.lap_number);
                end
                results_seen++;
            end
            if (s_valid && s_ready)
                expected_results.push_back(classify_sample(s_button_level, s_time_ms));
            waiting = expected_results.size();
        end
    end

endmodule

### dv/button_press_classifier_tb.sv
// Testbench top for the button press classifier: drives sample words and limit writes,
// throttles the result channel, and gives the verdict from the scoreboard's count.
// Depends on bpc_pkg, button_press_classifier and button_press_classifier_checker.
module button_press_classifier_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 6;
    localparam int PRESSES     = 32;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_button_level;
    logic [31:0] s_time_ms;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_press_event;
    logic [15:0] m_lap_number;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          errors;
    int          waiting;

    bit              idle_on;
    int              sink_hold;
    int              stalled;
    bpc_pkg::time_t  now_ms;
    bpc_pkg::limit_t short_lim;
    bpc_pkg::limit_t window_lim;
    bpc_pkg::limit_t long_lim;
    bpc_pkg::limit_t very_lim;

    button_press_classifier uut (.*);

    button_press_classifier_checker press_check (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: stall in random bursts while idling is on.
    always @(posedge aclk) begin
        if (idle_on && sink_hold == 0 && $urandom_range(0, 5) == 0)
            sink_hold = $urandom_range(1, 17);
        if (sink_hold > 0) begin
            sink_hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stalled <= 0;
        end else if (stalled == STALL_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("** button_press_classifier: FAILED **");
            $finish;
        end else begin
            stalled <= stalled + 1;
        end
    end

    task automatic send_sample(input logic level, input bpc_pkg::time_t stamp);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_button_level <= level;
        s_time_ms      <= stamp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic press(input bpc_pkg::time_t idle_ms, input bpc_pkg::time_t held_ms);
        now_ms += idle_ms;
        send_sample(1'b1, now_ms);
        now_ms += held_ms;
        send_sample(1'b0, now_ms);
    endtask

    // Drop valid and wait out every pending word, sampling away from the clock edge.
    task automatic drain(input int extra);
        s_valid <= 1'b0;
        @(negedge aclk);
        while (waiting != 0) @(negedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_word(input bpc_pkg::cfg_idx_t idx, input bpc_pkg::limit_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic load_limits(input bpc_pkg::limit_t sl, input bpc_pkg::limit_t wl,
                               input bpc_pkg::limit_t ll, input bpc_pkg::limit_t vl);
        drain(4);
        write_word(bpc_pkg::REG_SHORT_LIMIT, sl);
        write_word(bpc_pkg::REG_DOUBLE_WINDOW, wl);
        write_word(bpc_pkg::REG_LONG_LIMIT, ll);
        write_word(bpc_pkg::REG_VERY_LONG_LIMIT, vl);
        cfg_valid  <= 1'b0;
        short_lim  = sl;
        window_lim = wl;
        long_lim   = ll;
        very_lim   = vl;
    endtask

    // Hold times cluster on the limit boundaries of the current setting.
    function automatic bpc_pkg::time_t pick_hold();
        bpc_pkg::time_t hold;
        case ($urandom_range(0, 9))
            0, 1, 2: hold = (short_lim == 0) ? '0 : $urandom_range(0, short_lim - 1);
            3:       hold = short_lim;
            4:       hold = long_lim - 1;
            5:       hold = long_lim;
            6:       hold = very_lim - $urandom_range(0, 1);
            7:       hold = $urandom_range(0, 20000);
            8:       hold = $urandom;
            default: hold = $urandom_range(short_lim, very_lim);
        endcase
        return hold;
    endfunction

    function automatic bpc_pkg::time_t pick_idle();
        bpc_pkg::time_t gap;
        case ($urandom_range(0, 5))
            0, 1, 2: gap = $urandom_range(0, window_lim);
            3:       gap = window_lim;
            4:       gap = $urandom_range(0, 100000);
            default: gap = $urandom;
        endcase
        return gap;
    endfunction

    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_button_level <= 1'b0;
        s_time_ms      <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= bpc_pkg::REG_SHORT_LIMIT;
        cfg_data       <= '0;
        idle_on    = 1'b1;
        short_lim  = bpc_pkg::RST_SHORT_LIMIT;
        window_lim = bpc_pkg::RST_DOUBLE_WINDOW;
        long_lim   = bpc_pkg::RST_LONG_LIMIT;
        very_lim   = bpc_pkg::RST_VERY_LONG_LIMIT;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part on the reset limits.
        send_sample(1'b0, 32'h0000_0000);
        send_sample(1'b0, 32'hFFFF_FFFF);
        // short press across the timestamp wrap, with a steady high sample inside
        send_sample(1'b1, 32'hFFFF_FFF0);
        send_sample(1'b1, 32'h0000_0005);
        now_ms = 32'h0000_0010;
        send_sample(1'b0, now_ms);
        press(100, 99);
        press(100, 149);
        press(100, 150);
        // double still completes across a press that is neither short nor long
        press(10, 0);
        press(50, 20);
        press(400, 100);
        press(450, 49);
        press(10, 2999);
        press(10, 3000);
        press(10, 5999);
        press(10, 6000);
        press(10, 32'hFFFF_FFFF);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: load_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000);
                1: load_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: load_limits($urandom_range(1, 400), $urandom_range(1, 1000),
                               $urandom_range(500, 4000), $urandom_range(4001, 9000));
                3: load_limits($urandom_range(0, 400), $urandom_range(0, 1000),
                               $urandom_range(3000, 16'hFFFF), $urandom_range(0, 3000));
                4: load_limits($urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                               $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
                default: begin
                    idle_on = 1'b0;
                    load_limits(bpc_pkg::RST_SHORT_LIMIT, bpc_pkg::RST_DOUBLE_WINDOW,
                                bpc_pkg::RST_LONG_LIMIT, bpc_pkg::RST_VERY_LONG_LIMIT);
                end
            endcase
            now_ms = $urandom;
            for (int n = 0; n < PRESSES; n++) begin
                if (p < PHASES - 1 && n % 12 == 0)
                    idle_on = $urandom_range(0, 2) != 0;
                // stray sample at a random level and time; breaks the press now and then
                if ($urandom_range(0, 6) == 0)
                    send_sample($urandom_range(0, 1), $urandom);
                press(pick_idle(), pick_hold());
            end
        end

        drain(8);
        if (errors == 0) begin
            $display("** button_press_classifier: PASSED **");
        end else begin
            $display("** button_press_classifier: FAILED **");
        end
        $finish;
    end

endmodule

### button_press_classifier.f
sv/bpc_pkg.sv
sv/bpc_cfg_regs.sv
sv/bpc_classify.sv
sv/button_press_classifier.sv
sv/bpc_checker.sv
dv/button_press_classifier_checker.sv
dv/button_press_classifier_tb.sv
